>>> hdl/cyclic_ntt_poly_multiplier_assert.svh
// Assertion macros for the cyclic NTT polynomial multiplier.
// Expects clk_i and rst_ni in the including module's scope.
`ifndef CYCLIC_NTT_POLY_MULTIPLIER_ASSERT_SVH
`define CYCLIC_NTT_POLY_MULTIPLIER_ASSERT_SVH

// Condition and consequence in the same cycle.
`define CNPM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequence in the cycle after the condition.
`define CNPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/cnpm_pkg.sv
// Shared types and codes for the cyclic NTT polynomial multiplier.
// No dependencies.
package cnpm_pkg;

  localparam int COEFF_W   = 12;
  localparam int POS_W     = 8;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;
  localparam int MODE_W    = 2;

  // Item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Result status
  localparam logic STAT_OK        = 1'b0;
  localparam logic STAT_NOT_READY = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT = 1'b1;

  // Modes
  localparam logic [MODE_W-1:0] MODE_FWD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INV  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PROD = 2'd2;

  localparam logic [CFG_W-1:0] ROOT_RESET = 12'd17;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_READ,
    ST_ROOT,
    ST_ROOT_W,
    ST_POW_A,
    ST_POW_B,
    ST_POW_W,
    ST_CHAIN,
    ST_CHAIN_W,
    ST_PERM,
    ST_BFLY,
    ST_PR0,
    ST_PR1,
    ST_PI0,
    ST_PI1,
    ST_PI2,
    ST_PWAIT,
    ST_WR0,
    ST_WR1,
    ST_EL0,
    ST_EL1,
    ST_EL_W
  } st_e;

endpackage

>>> hdl/cnpm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cnpm_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/cnpm_modmul.sv
// Pipelined modular multiplier: Barrett reduction, four register stages.
// No dependencies.
module cnpm_modmul #(
  parameter int MODULUS = 3329,
  parameter int CW      = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [CW-1:0] x_i,
  input  logic [CW-1:0] y_i,
  output logic          valid_o,
  output logic [CW-1:0] res_o
);

  localparam int W  = $clog2(MODULUS);
  localparam int PW = 2 * CW;
  localparam int K  = PW;
  localparam int QW = K - W + 1;
  localparam logic [QW-1:0] MU   = QW'((64'd1 << K) / MODULUS);
  localparam logic [W:0]    MODV = (W+1)'(MODULUS);

  logic [3:0]       vld_q;
  logic [PW-1:0]    p1_q;
  logic [QW-1:0]    q_q;
  logic [W:0]       plo_q;
  logic [W:0]       plo2_q;
  logic [W:0]       qm_q;
  logic [W-1:0]     res_q;
  logic [PW+QW-1:0] t;
  logic [QW+W-1:0]  qm_full;
  logic [W:0]       r;

  // Quotient estimate, then the multiple to subtract
  assign t       = (PW+QW)'(p1_q) * (PW+QW)'(MU);
  assign qm_full = (QW+W)'(q_q) * (QW+W)'(MODULUS);
  assign r       = plo2_q - qm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q   <= PW'(x_i) * PW'(y_i);
    q_q    <= t[PW+QW-1:K];
    plo_q  <= p1_q[W:0];
    qm_q   <= qm_full[W:0];
    plo2_q <= plo_q;
    // remainder is below twice the modulus: one correction
    res_q  <= (r >= MODV) ? W'(r - MODV) : W'(r);
  end

  assign valid_o = vld_q[3];
  assign res_o   = CW'(res_q);

endmodule

>>> hdl/cyclic_ntt_poly_multiplier.sv
// Cyclic radix-2 NTT engine: forward, inverse, or cyclic product mod q.
// Depends on cnpm_pkg, cnpm_ram, cnpm_modmul, cyclic_ntt_poly_multiplier_assert.svh.
//
// Channel   Ports                                       Handshake
// command   start_i kind_i coeff_a_i coeff_b_i          start_i & !busy_o
// result    coeff_o position_o last_o status_o          strobe_o, one cycle
// config    cfg_we_i cfg_idx_i cfg_data_i               cfg_we_i
//
// Loads are written to both stores as they are accepted. The DEGREE-th load
// starts the compute, which runs on one shared modular multiplier and one
// read port per store. A ready read passes through the read state before its
// word is registered; a not-ready read shows its word in the cycle after
// acceptance. Reset clears control only; results cannot be stalled.
`include "cyclic_ntt_poly_multiplier_assert.svh"

module cyclic_ntt_poly_multiplier #(
  parameter int DEGREE  = 256,
  parameter int MODULUS = 3329
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic                           kind_i,
  input  logic [cnpm_pkg::COEFF_W-1:0]   coeff_a_i,
  input  logic [cnpm_pkg::COEFF_W-1:0]   coeff_b_i,
  output logic                           strobe_o,
  output logic [cnpm_pkg::COEFF_W-1:0]   coeff_o,
  output logic [cnpm_pkg::POS_W-1:0]     position_o,
  output logic                           last_o,
  output logic                           status_o,
  input  logic                           cfg_we_i,
  input  logic [cnpm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [cnpm_pkg::CFG_W-1:0]     cfg_data_i
);
  import cnpm_pkg::*;

  localparam int LOGD = $clog2(DEGREE);
  localparam int AW   = LOGD;
  localparam int SW   = $clog2(LOGD);
  localparam int W    = $clog2(MODULUS);
  localparam int CW   = (W > COEFF_W) ? W : COEFF_W;
  localparam int PBW  = $clog2(W);
  localparam logic [W-1:0]    EXP_INV = W'(MODULUS - 2);
  localparam logic [W-1:0]    DMOD    = W'(DEGREE % MODULUS);
  localparam logic [W-1:0]    ONE     = W'(1);
  localparam logic [W:0]      MODV    = (W+1)'(MODULUS);
  localparam logic [AW-1:0]   LASTI   = AW'(DEGREE - 1);
  localparam logic [AW-2:0]   LASTBF  = (AW-1)'(DEGREE / 2 - 1);
  localparam logic [SW-1:0]   LASTST  = SW'(LOGD - 1);
  localparam logic [PBW-1:0]  LASTPB  = PBW'(W - 1);

  function automatic logic [AW-1:0] bitrev(input logic [AW-1:0] v);
    logic [AW-1:0] o;
    for (int b = 0; b < AW; b++) begin
      o[b] = v[AW-1-b];
    end
    return o;
  endfunction

  // Control state
  st_e              state_q, state_d;
  logic [MODE_W-1:0] mode_q, mode_d, mode_lat_q, mode_lat_d;
  logic [CFG_W-1:0] root_q, root_d, root_lat_q, root_lat_d;
  logic [AW-1:0]    load_cnt_q, load_cnt_d, read_cnt_q, read_cnt_d;
  logic             ready_q, ready_d, strobe_q, strobe_d;
  logic [1:0]       tr_q, tr_d, rcv_q, rcv_d;
  logic             sel_b_q, sel_b_d, op_bfly_q, op_bfly_d;
  logic             el_pw_q, el_pw_d, pow_sc_q, pow_sc_d;
  logic [PBW-1:0]   pbit_q, pbit_d;
  logic [SW-1:0]    jx_q, jx_d, st_q, st_d;
  logic [AW-2:0]    bf_q, bf_d;
  logic [AW-1:0]    idx_q, idx_d;

  // Datapath
  logic [W-1:0]     rootx_q, rootx_d, rootinv_q, rootinv_d, sc_q, sc_d;
  logic [W-1:0]     pacc_q, pacc_d, pb_q, pb_d, w_q, w_d;
  logic [W-1:0]     tw_q [LOGD];
  logic [W-1:0]     tw_d [LOGD];
  logic [CW-1:0]    u_q, u_d;
  logic [W-1:0]     r0_q, r0_d, r1_q, r1_d;
  logic [AW-1:0]    ax_q, ax_d, bx_q, bx_d;
  logic [COEFF_W-1:0] coeff_q, coeff_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             last_q, last_d, status_q, status_d;

  // Memories and multiplier
  logic             we_a, we_b;
  logic [AW-1:0]    waddr, raddr;
  logic [CW-1:0]    wdata_a, wdata_b, rd_a, rd_b, rdsel;
  logic             mm_vin, mm_vout;
  logic [CW-1:0]    mm_x, mm_y, mm_res;

  // Butterfly helpers
  logic             acc;
  logic [AW-1:0]    bfx, bmask, bhalf, bax;
  logic [SW-1:0]    twi;
  logic [W-1:0]     wl, add_r, sub_r;
  logic [W:0]       sum;
  logic [AW-1:0]    ridx;

  assign acc   = start_i && !busy_o;
  assign busy_o = (state_q != ST_IDLE);
  assign rdsel = sel_b_q ? rd_b : rd_a;
  assign ridx  = bitrev(idx_q);

  assign bfx   = AW'(bf_q);
  assign bhalf = AW'(1) << st_q;
  assign bmask = bhalf - AW'(1);
  assign bax   = ((bfx >> st_q) << (st_q + SW'(1))) | (bfx & bmask);
  assign twi   = LASTST - st_q;
  assign wl    = tw_q[twi];

  // u + v and u - v, both mod q
  assign sum   = (W+1)'(r1_q) + (W+1)'(r0_q);
  assign add_r = (sum >= MODV) ? W'(sum - MODV) : W'(sum);
  assign sub_r = (r1_q >= r0_q) ? (r1_q - r0_q) : W'(MODV + (W+1)'(r1_q) - (W+1)'(r0_q));

  cnpm_ram #(.WIDTH(CW), .DEPTH(DEGREE)) u_ram_a (
    .clk_i, .we_i(we_a), .waddr_i(waddr), .wdata_i(wdata_a),
    .raddr_i(raddr), .rdata_o(rd_a)
  );

  cnpm_ram #(.WIDTH(CW), .DEPTH(DEGREE)) u_ram_b (
    .clk_i, .we_i(we_b), .waddr_i(waddr), .wdata_i(wdata_b),
    .raddr_i(raddr), .rdata_o(rd_b)
  );

  cnpm_modmul #(.MODULUS(MODULUS), .CW(CW)) u_modmul (
    .clk_i, .rst_ni, .valid_i(mm_vin), .x_i(mm_x), .y_i(mm_y),
    .valid_o(mm_vout), .res_o(mm_res)
  );

  // Sequencer: next state, memory and multiplier controls
  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    root_d     = root_q;
    mode_lat_d = mode_lat_q;
    root_lat_d = root_lat_q;
    load_cnt_d = load_cnt_q;
    read_cnt_d = read_cnt_q;
    ready_d    = ready_q;
    strobe_d   = 1'b0;
    tr_d       = tr_q;
    rcv_d      = rcv_q;
    sel_b_d    = sel_b_q;
    op_bfly_d  = op_bfly_q;
    el_pw_d    = el_pw_q;
    pow_sc_d   = pow_sc_q;
    pbit_d     = pbit_q;
    jx_d       = jx_q;
    st_d       = st_q;
    bf_d       = bf_q;
    idx_d      = idx_q;
    rootx_d    = rootx_q;
    rootinv_d  = rootinv_q;
    sc_d       = sc_q;
    pacc_d     = pacc_q;
    pb_d       = pb_q;
    w_d        = w_q;
    tw_d       = tw_q;
    u_d        = u_q;
    r0_d       = r0_q;
    r1_d       = r1_q;
    ax_d       = ax_q;
    bx_d       = bx_q;
    coeff_d    = coeff_q;
    pos_d      = pos_q;
    last_d     = last_q;
    status_d   = status_q;
    we_a       = 1'b0;
    we_b       = 1'b0;
    waddr      = ax_q;
    raddr      = ax_q;
    wdata_a    = '0;
    wdata_b    = '0;
    mm_vin     = 1'b0;
    mm_x       = '0;
    mm_y       = CW'(ONE);

    // configuration writes
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE: mode_d = cfg_data_i[MODE_W-1:0];
        CFG_ROOT: root_d = cfg_data_i;
        default:  root_d = root_q;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (acc && kind_i == KIND_LOAD) begin
          we_a    = 1'b1;
          we_b    = 1'b1;
          waddr   = load_cnt_q;
          wdata_a = CW'(coeff_a_i);
          wdata_b = CW'(coeff_b_i);
          ready_d = 1'b0;
          if (load_cnt_q == LASTI) begin
            load_cnt_d = '0;
            mode_lat_d = mode_q;
            root_lat_d = root_q;
            state_d    = ST_ROOT;
          end else begin
            load_cnt_d = load_cnt_q + AW'(1);
          end
        end else if (acc && kind_i == KIND_READ) begin
          if (ready_q) begin
            raddr   = read_cnt_q;
            state_d = ST_READ;
          end else begin
            strobe_d = 1'b1;
            coeff_d  = '0;
            pos_d    = '0;
            last_d   = 1'b0;
            status_d = STAT_NOT_READY;
          end
        end
      end

      ST_READ: begin
        strobe_d = 1'b1;
        coeff_d  = rd_a[COEFF_W-1:0];
        pos_d    = POS_W'(read_cnt_q);
        last_d   = (read_cnt_q == LASTI);
        status_d = STAT_OK;
        if (read_cnt_q == LASTI) begin
          read_cnt_d = '0;
          ready_d    = 1'b0;
        end else begin
          read_cnt_d = read_cnt_q + AW'(1);
        end
        state_d = ST_IDLE;
      end

      // reduce the root
      ST_ROOT: begin
        mm_vin  = 1'b1;
        mm_x    = CW'(root_lat_q);
        state_d = ST_ROOT_W;
      end

      ST_ROOT_W: begin
        if (mm_vout) begin
          rootx_d  = W'(mm_res);
          pb_d     = W'(mm_res);
          pacc_d   = ONE;
          pbit_d   = '0;
          pow_sc_d = 1'b0;
          state_d  = ST_POW_A;
        end
      end

      // square and multiply, exponent q-2, low bit first
      ST_POW_A: begin
        mm_vin  = 1'b1;
        mm_x    = CW'(pacc_q);
        mm_y    = CW'(pb_q);
        state_d = ST_POW_B;
      end

      ST_POW_B: begin
        mm_vin  = 1'b1;
        mm_x    = CW'(pb_q);
        mm_y    = CW'(pb_q);
        rcv_d   = '0;
        state_d = ST_POW_W;
      end

      ST_POW_W: begin
        if (mm_vout) begin
          if (rcv_q == 2'd0) begin
            if (EXP_INV[pbit_q]) begin
              pacc_d = W'(mm_res);
            end
            rcv_d = 2'd1;
          end else begin
            pb_d = W'(mm_res);
            if (pbit_q == LASTPB) begin
              if (!pow_sc_q) begin
                rootinv_d = pacc_q;
                pacc_d    = ONE;
                pb_d      = DMOD;
                pbit_d    = '0;
                pow_sc_d  = 1'b1;
                state_d   = ST_POW_A;
              end else begin
                sc_d    = pacc_q;
                tr_d    = 2'd0;
                sel_b_d = 1'b0;
                tw_d[0] = (mode_lat_q == MODE_INV) ? rootinv_q : rootx_q;
                jx_d    = SW'(1);
                state_d = ST_CHAIN;
              end
            end else begin
              pbit_d  = pbit_q + PBW'(1);
              state_d = ST_POW_A;
            end
          end
        end
      end

      // stage twiddles: repeated squares of the base root
      ST_CHAIN: begin
        mm_vin  = 1'b1;
        mm_x    = CW'(tw_q[jx_q - SW'(1)]);
        mm_y    = CW'(tw_q[jx_q - SW'(1)]);
        state_d = ST_CHAIN_W;
      end

      ST_CHAIN_W: begin
        if (mm_vout) begin
          tw_d[jx_q] = W'(mm_res);
          if (jx_q == LASTST) begin
            idx_d   = '0;
            state_d = ST_PERM;
          end else begin
            jx_d    = jx_q + SW'(1);
            state_d = ST_CHAIN;
          end
        end
      end

      // bit-reversal swap, also reduces raw loaded words
      ST_PERM: begin
        if (idx_q <= ridx) begin
          ax_d      = idx_q;
          bx_d      = ridx;
          op_bfly_d = 1'b0;
          state_d   = ST_PR0;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end

      ST_BFLY: begin
        ax_d      = bax;
        bx_d      = bax | bhalf;
        op_bfly_d = 1'b1;
        if ((bfx & bmask) == '0) begin
          w_d = ONE;
        end
        state_d = ST_PR0;
      end

      // pair operation: read both, multiply, write both
      ST_PR0: begin
        raddr   = ax_q;
        state_d = ST_PR1;
      end

      ST_PR1: begin
        raddr   = bx_q;
        u_d     = rdsel;
        state_d = ST_PI0;
      end

      ST_PI0: begin
        mm_vin  = 1'b1;
        mm_x    = rdsel;
        mm_y    = op_bfly_q ? CW'(w_q) : CW'(ONE);
        state_d = ST_PI1;
      end

      ST_PI1: begin
        mm_vin  = 1'b1;
        mm_x    = u_q;
        state_d = ST_PI2;
      end

      ST_PI2: begin
        mm_vin  = 1'b1;
        mm_x    = CW'(w_q);
        mm_y    = CW'(wl);
        rcv_d   = '0;
        state_d = ST_PWAIT;
      end

      ST_PWAIT: begin
        if (mm_vout) begin
          unique case (rcv_q)
            2'd0: begin
              r0_d  = W'(mm_res);
              rcv_d = 2'd1;
            end
            2'd1: begin
              r1_d  = W'(mm_res);
              rcv_d = 2'd2;
            end
            default: begin
              if (op_bfly_q) begin
                w_d = W'(mm_res);
              end
              state_d = ST_WR0;
            end
          endcase
        end
      end

      ST_WR0: begin
        waddr   = ax_q;
        wdata_a = CW'(op_bfly_q ? add_r : r0_q);
        wdata_b = wdata_a;
        we_a    = !sel_b_q;
        we_b    = sel_b_q;
        state_d = ST_WR1;
      end

      ST_WR1: begin
        waddr   = bx_q;
        wdata_a = CW'(op_bfly_q ? sub_r : r1_q);
        wdata_b = wdata_a;
        we_a    = !sel_b_q;
        we_b    = sel_b_q;
        if (!op_bfly_q) begin
          if (idx_q == LASTI) begin
            st_d    = '0;
            bf_d    = '0;
            state_d = ST_BFLY;
          end else begin
            idx_d   = idx_q + AW'(1);
            state_d = ST_PERM;
          end
        end else if (bf_q != LASTBF) begin
          bf_d    = bf_q + (AW-1)'(1);
          state_d = ST_BFLY;
        end else if (st_q != LASTST) begin
          bf_d    = '0;
          st_d    = st_q + SW'(1);
          state_d = ST_BFLY;
        end else begin
          // transform finished: pick the next step of the mode
          idx_d = '0;
          priority if (mode_lat_q == MODE_FWD) begin
            ready_d    = 1'b1;
            read_cnt_d = '0;
            state_d    = ST_IDLE;
          end else if (mode_lat_q == MODE_INV || tr_q == 2'd2) begin
            el_pw_d = 1'b0;
            state_d = ST_EL0;
          end else if (tr_q == 2'd0) begin
            tr_d    = 2'd1;
            sel_b_d = 1'b1;
            tw_d[0] = rootx_q;
            jx_d    = SW'(1);
            state_d = ST_CHAIN;
          end else begin
            el_pw_d = 1'b1;
            state_d = ST_EL0;
          end
        end
      end

      // element pass: pointwise product or inverse scaling, into A
      ST_EL0: begin
        raddr   = idx_q;
        state_d = ST_EL1;
      end

      ST_EL1: begin
        mm_vin  = 1'b1;
        mm_x    = rd_a;
        mm_y    = el_pw_q ? rd_b : CW'(sc_q);
        state_d = ST_EL_W;
      end

      ST_EL_W: begin
        if (mm_vout) begin
          we_a    = 1'b1;
          waddr   = idx_q;
          wdata_a = mm_res;
          if (idx_q != LASTI) begin
            idx_d   = idx_q + AW'(1);
            state_d = ST_EL0;
          end else if (el_pw_q) begin
            tr_d    = 2'd2;
            sel_b_d = 1'b0;
            tw_d[0] = rootinv_q;
            jx_d    = SW'(1);
            state_d = ST_CHAIN;
          end else begin
            ready_d    = 1'b1;
            read_cnt_d = '0;
            state_d    = ST_IDLE;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      mode_q     <= MODE_PROD;
      root_q     <= ROOT_RESET;
      mode_lat_q <= MODE_PROD;
      load_cnt_q <= '0;
      read_cnt_q <= '0;
      ready_q    <= 1'b0;
      strobe_q   <= 1'b0;
      tr_q       <= '0;
      rcv_q      <= '0;
      sel_b_q    <= 1'b0;
      op_bfly_q  <= 1'b0;
      el_pw_q    <= 1'b0;
      pow_sc_q   <= 1'b0;
      pbit_q     <= '0;
      jx_q       <= '0;
      st_q       <= '0;
      bf_q       <= '0;
      idx_q      <= '0;
    end else begin
      state_q    <= state_d;
      mode_q     <= mode_d;
      root_q     <= root_d;
      mode_lat_q <= mode_lat_d;
      load_cnt_q <= load_cnt_d;
      read_cnt_q <= read_cnt_d;
      ready_q    <= ready_d;
      strobe_q   <= strobe_d;
      tr_q       <= tr_d;
      rcv_q      <= rcv_d;
      sel_b_q    <= sel_b_d;
      op_bfly_q  <= op_bfly_d;
      el_pw_q    <= el_pw_d;
      pow_sc_q   <= pow_sc_d;
      pbit_q     <= pbit_d;
      jx_q       <= jx_d;
      st_q       <= st_d;
      bf_q       <= bf_d;
      idx_q      <= idx_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    root_lat_q <= root_lat_d;
    rootx_q    <= rootx_d;
    rootinv_q  <= rootinv_d;
    sc_q       <= sc_d;
    pacc_q     <= pacc_d;
    pb_q       <= pb_d;
    w_q        <= w_d;
    tw_q       <= tw_d;
    u_q        <= u_d;
    r0_q       <= r0_d;
    r1_q       <= r1_d;
    ax_q       <= ax_d;
    bx_q       <= bx_d;
    coeff_q    <= coeff_d;
    pos_q      <= pos_d;
    last_q     <= last_d;
    status_q   <= status_d;
  end

  assign strobe_o   = strobe_q;
  assign coeff_o    = coeff_q;
  assign position_o = pos_q;
  assign last_o     = last_q;
  assign status_o   = status_q;

  `CNPM_ASSERT_NOW(a_mm_only_in_compute, mm_vout,
    state_q != ST_IDLE && state_q != ST_READ, "multiplier result outside compute")
  `CNPM_ASSERT_NOW(a_ready_frame_empty, ready_q, load_cnt_q == '0,
    "results ready with a partial frame")
  `CNPM_ASSERT_NOW(a_ok_from_read, strobe_q && status_q == STAT_OK,
    $past(state_q == ST_READ), "valid word without a memory read")
  `CNPM_ASSERT_NEXT(a_read_launch, acc && kind_i == KIND_READ && ready_q,
    state_q == ST_READ, "ready read did not reach the read state")

endmodule

>>> bench/testbench.sv
// Self-checking bench for the cyclic NTT polynomial multiplier.
// Depends on cnpm_pkg and cyclic_ntt_poly_multiplier; predicts every result word.
module testbench;
  import cnpm_pkg::*;

  localparam int DEG       = 256;
  localparam int LOG_DEG   = 8;
  localparam int Q         = 3329;
  localparam int WDOG_MAX  = 400000;

  typedef struct packed {
    logic [COEFF_W-1:0] coeff;
    logic [POS_W-1:0]   position;
    logic               last;
    logic               status;
  } word_t;

  typedef struct {
    logic               kind;
    logic [COEFF_W-1:0] a;
    logic [COEFF_W-1:0] b;
    bit                 typed;
    word_t              want;
  } row_t;

  logic               clk_i, rst_ni;
  logic               start_i, busy_o, kind_i;
  logic [COEFF_W-1:0] coeff_a_i, coeff_b_i;
  logic               strobe_o;
  logic [COEFF_W-1:0] coeff_o;
  logic [POS_W-1:0]   position_o;
  logic               last_o, status_o;
  logic               cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]   cfg_data_i;

  cyclic_ntt_poly_multiplier u_dut (.*);

  // Predictor state
  int unsigned    poly_a [DEG];
  int unsigned    poly_b [DEG];
  int unsigned    load_cnt, read_cnt;
  bit             frame_done;
  logic [MODE_W-1:0] cur_mode;
  logic [CFG_W-1:0]  cur_root;

  word_t pending_words[$];
  int    fail_cnt;
  int    idle_pct;
  int    wdog;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned mod_mul(int unsigned x, int unsigned y);
    return (x * y) % Q;
  endfunction

  function automatic int unsigned mod_pow(int unsigned b, int unsigned e);
    int unsigned r;
    r = 1;
    b = b % Q;
    while (e != 0) begin
      if (e[0]) r = mod_mul(r, b);
      b = mod_mul(b, b);
      e = e >> 1;
    end
    return r;
  endfunction

  // Bit-reversal permutation then Cooley-Tukey stages, in place on A or B; inverse scales by 1/DEG
  function automatic void ntt_pass(bit on_b, bit inv);
    int unsigned p [DEG];
    int unsigned j, len, half, w, wl, u, v, sc;
    logic [LOG_DEG-1:0] ib;
    logic [LOG_DEG-1:0] jb;
    for (int i = 0; i < DEG; i++) p[i] = on_b ? poly_b[i] : poly_a[i];
    for (int i = 1; i < DEG; i++) begin
      ib = i[LOG_DEG-1:0];
      jb = {<<{ib}};
      j  = jb;
      if (i < j) begin
        u = p[i]; p[i] = p[j]; p[j] = u;
      end
    end
    len = 2;
    while (len <= DEG) begin
      half = len >> 1;
      wl = mod_pow(cur_root % Q, DEG / len);
      if (inv) wl = mod_pow(wl, Q - 2);
      for (int i = 0; i + len <= DEG; i += len) begin
        w = 1;
        for (int k = 0; k < half; k++) begin
          u = p[i+k];
          v = mod_mul(p[i+k+half], w);
          p[i+k]      = (u + v >= Q) ? u + v - Q : u + v;
          p[i+k+half] = (u >= v) ? u - v : Q + u - v;
          w = mod_mul(w, wl);
        end
      end
      len = len << 1;
    end
    if (inv) begin
      sc = mod_pow(DEG % Q, Q - 2);
      for (int i = 0; i < DEG; i++) p[i] = mod_mul(p[i], sc);
    end
    for (int i = 0; i < DEG; i++)
      if (on_b) poly_b[i] = p[i];
      else poly_a[i] = p[i];
  endfunction

  // Advance the predicted state by one accepted word; returns 1 if a result is due
  function automatic bit predict_word(logic k, logic [COEFF_W-1:0] a,
                                      logic [COEFF_W-1:0] b, output word_t res);
    res = '0;
    if (k == KIND_LOAD) begin
      if (frame_done || load_cnt >= DEG) begin
        frame_done = 0;
        load_cnt = 0;
      end
      poly_a[load_cnt] = a % Q;
      poly_b[load_cnt] = b % Q;
      load_cnt++;
      if (load_cnt == DEG) begin
        if (cur_mode == MODE_FWD) ntt_pass(0, 0);
        else if (cur_mode == MODE_INV) ntt_pass(0, 1);
        else begin
          ntt_pass(0, 0);
          ntt_pass(1, 0);
          for (int i = 0; i < DEG; i++) poly_a[i] = mod_mul(poly_a[i], poly_b[i]);
          ntt_pass(0, 1);
        end
        load_cnt = 0;
        read_cnt = 0;
        frame_done = 1;
      end
      return 0;
    end
    if (!frame_done || read_cnt >= DEG) begin
      res.status = STAT_NOT_READY;
      return 1;
    end
    res.coeff    = poly_a[read_cnt][COEFF_W-1:0];
    res.position = read_cnt[POS_W-1:0];
    res.last     = (read_cnt == DEG - 1);
    res.status   = STAT_OK;
    read_cnt++;
    if (read_cnt >= DEG) begin
      frame_done = 0;
      read_cnt = 0;
    end
    return 1;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d", field, got, want);
    fail_cnt++;
  endtask

  // Send one command word; optional typed expectation overrides the prediction
  task automatic send_word(logic k, logic [COEFF_W-1:0] a, logic [COEFF_W-1:0] b,
                           bit typed = 0, word_t want = '0);
    word_t res;
    bit    due;
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i   <= 1'b1;
    kind_i    <= k;
    coeff_a_i <= a;
    coeff_b_i <= b;
    do @(posedge clk_i); while (busy_o);
    due = predict_word(k, a, b, res);
    if (due) pending_words.push_back(typed ? want : res);
  endtask

  // Wait until quiet, then write both registers
  task automatic write_config(logic [MODE_W-1:0] m, logic [CFG_W-1:0] r);
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_words.size() != 0 || busy_o) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_MODE;
    cfg_data_i <= CFG_W'(m);
    @(posedge clk_i);
    cur_mode = m;
    cfg_idx_i  <= CFG_ROOT;
    cfg_data_i <= r;
    @(posedge clk_i);
    cur_root = r;
    cfg_we_i <= 1'b0;
  endtask

  // Result checker
  always @(posedge clk_i) begin
    word_t exp_w;
    if (rst_ni && strobe_o) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word at position", position_o, 0);
      end else begin
        exp_w = pending_words.pop_front();
        if (coeff_o !== exp_w.coeff) report_mismatch("coeff", coeff_o, exp_w.coeff);
        if (position_o !== exp_w.position)
          report_mismatch("position", position_o, exp_w.position);
        if (last_o !== exp_w.last) report_mismatch("last", last_o, exp_w.last);
        if (status_o !== exp_w.status) report_mismatch("status", status_o, exp_w.status);
      end
    end
  end

  // Watchdog on cycles with no progress
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || strobe_o) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_MAX) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    row_t  rows [$];
    word_t nr;
    int    modes [5];
    int    roots [5];
    int    nreads;
    logic [COEFF_W-1:0] ra, rb;

    rst_ni     = 1'b0;
    start_i    = 1'b0;
    kind_i     = KIND_LOAD;
    coeff_a_i  = '0;
    coeff_b_i  = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_MODE;
    cfg_data_i = '0;
    fail_cnt   = 0;
    idle_pct   = 0;
    wdog       = 0;
    cur_mode   = MODE_PROD;
    cur_root   = ROOT_RESET;
    load_cnt   = 0;
    read_cnt   = 0;
    frame_done = 0;
    for (int i = 0; i < DEG; i++) begin
      poly_a[i] = 0;
      poly_b[i] = 0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reads before any result, loads at the field extremes
    nr = '0;
    nr.status = STAT_NOT_READY;
    rows.push_back('{KIND_READ, 12'd0,    12'd0,    1, nr});
    rows.push_back('{KIND_LOAD, 12'd0,    12'd0,    0, '0});
    rows.push_back('{KIND_LOAD, 12'd4095, 12'd4095, 0, '0});
    rows.push_back('{KIND_READ, 12'd4095, 12'd4095, 1, nr});
    rows.push_back('{KIND_LOAD, 12'd3328, 12'd3329, 0, '0});
    rows.push_back('{KIND_LOAD, 12'd3329, 12'd3328, 0, '0});
    rows.push_back('{KIND_LOAD, 12'd2730, 12'd1365, 0, '0});
    rows.push_back('{KIND_LOAD, 12'd1365, 12'd2730, 0, '0});
    rows.push_back('{KIND_READ, 12'd0,    12'd0,    1, nr});
    rows.push_back('{KIND_LOAD, 12'd1,    12'd2048, 0, '0});
    foreach (rows[i]) send_word(rows[i].kind, rows[i].a, rows[i].b, rows[i].typed,
                                rows[i].want);

    // One frame per setting; mode and root extremes included
    modes = '{MODE_PROD, MODE_FWD, MODE_INV, 3, MODE_PROD};
    roots = '{17, 3328, 1, 4095, 0};
    for (int f = 0; f < 5; f++) begin
      write_config(MODE_W'(modes[f]), CFG_W'(roots[f]));
      case (f % 3)
        0: idle_pct = 0;
        1: idle_pct = 87;
        default: idle_pct = 37;
      endcase
      // loads, with the odd stray read while the frame fills
      while (load_cnt < DEG - 1 || frame_done) begin
        if ($urandom_range(99) < 5) begin
          send_word(KIND_READ, 12'($urandom), 12'($urandom));
        end else begin
          if ($urandom_range(9) == 0) begin
            ra = 12'($urandom);
            rb = 12'($urandom);
          end else begin
            ra = 12'($urandom_range(Q - 1));
            rb = 12'($urandom_range(Q - 1));
          end
          send_word(KIND_LOAD, ra, rb);
        end
      end
      send_word(KIND_LOAD, 12'($urandom_range(Q - 1)), 12'($urandom_range(Q - 1)));
      // frame 2 is cut short so the next load restarts it; others read past the end
      nreads = (f == 2) ? 100 : DEG + 3;
      for (int i = 0; i < nreads; i++) send_word(KIND_READ, 12'($urandom), 12'($urandom));
      if (f == 0) begin
        // hold off until the frame has fully drained
        start_i <= 1'b0;
        @(posedge clk_i);
        while (pending_words.size() != 0) @(posedge clk_i);
      end
    end

    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

>>> cyclic_ntt_poly_multiplier.f
+incdir+hdl
hdl/cnpm_pkg.sv
hdl/cnpm_ram.sv
hdl/cnpm_modmul.sv
hdl/cyclic_ntt_poly_multiplier.sv
bench/testbench.sv
